/* rtl/core/cas_pkg.sv */
// shared constants and types for the capacitance acquire sequencer
`default_nettype none

package cas_pkg;

  localparam int SAMPLE_COUNT = 5;
  localparam int SAMPLE_W     = 32;
  localparam int SIDX_W       = 3;

  // phase codes
  localparam logic [3:0] PH_NOTINIT   = 4'd0;
  localparam logic [3:0] PH_INITDONE  = 4'd1;
  localparam logic [3:0] PH_WAITINT   = 4'd2;
  localparam logic [3:0] PH_WAITREADY = 4'd3;
  localparam logic [3:0] PH_CONFIRM   = 4'd4;
  localparam logic [3:0] PH_SAMPLING  = 4'd5;
  localparam logic [3:0] PH_VALID     = 4'd6;
  localparam logic [3:0] PH_TIMEOUT   = 4'd7;
  localparam logic [3:0] PH_NOTREADY  = 4'd8;
  localparam logic [3:0] PH_FAULT     = 4'd9;

  // event codes
  localparam logic [2:0] FN_INIT  = 3'd0;
  localparam logic [2:0] FN_START = 3'd1;
  localparam logic [2:0] FN_TICK  = 3'd2;
  localparam logic [2:0] FN_INTR  = 3'd3;
  localparam logic [2:0] FN_DATA  = 3'd4;

  // configuration register indexes
  localparam logic [2:0] CFG_TIMEOUT   = 3'd0;
  localparam logic [2:0] CFG_THRESHOLD = 3'd1;
  localparam logic [2:0] CFG_READY_BIT = 3'd2;
  localparam logic [2:0] CFG_STAT_ADDR = 3'd3;
  localparam logic [2:0] CFG_SAMP_ADDR = 3'd4;

  // configuration reset values
  localparam logic [15:0] RST_TIMEOUT   = 16'd200;
  localparam logic [7:0]  RST_THRESHOLD = 8'd5;
  localparam logic [4:0]  RST_READY_BIT = 5'd20;
  localparam logic [7:0]  RST_STAT_ADDR = 8'd8;
  localparam logic [7:0]  RST_SAMP_ADDR = 8'd1;

  typedef logic [SAMPLE_COUNT-1:0][SAMPLE_W-1:0] sample_vec_t;

endpackage

`default_nettype wire

/* rtl/core/cas_median5.sv */
// median of five unsigned samples by rank counting
`default_nettype none

module cas_median5 import cas_pkg::*; (
  input  wire sample_vec_t           samples,
  output logic [SAMPLE_W-1:0]        median
);

  localparam int RANK_W = $clog2(SAMPLE_COUNT);
  localparam logic [RANK_W-1:0] MID_RANK = RANK_W'(SAMPLE_COUNT / 2);

  logic [SAMPLE_COUNT-1:0][RANK_W-1:0] rank;

  // rank = number of elements ordered before this one, ties broken by position
  always_comb begin
    for (int i = 0; i < SAMPLE_COUNT; i++) begin
      rank[i] = '0;
      for (int j = 0; j < SAMPLE_COUNT; j++) begin
        if (j != i) begin
          if ((samples[j] < samples[i]) || ((samples[j] == samples[i]) && (j < i))) begin
            rank[i] = rank[i] + RANK_W'(1);
          end
        end
      end
    end
  end

  always_comb begin
    median = '0;
    for (int i = 0; i < SAMPLE_COUNT; i++) begin
      if (rank[i] == MID_RANK) begin
        median = samples[i];
      end
    end
  end

endmodule

`default_nettype wire

/* rtl/core/capacitance_acquire_sequencer.sv */
// Capacitance acquire sequencer: one event item in, one status item out per event.
// Each accepted item (init, start, tick, interrupt or read data) updates the
// measurement state in the cycle it is accepted, and its result item appears in
// the output register on the next cycle; a new item is taken every cycle while
// the output register is empty or being drained, so throughput is one item per
// cycle. The longest path is the five-way median rank network that runs when the
// fifth sample arrives. The user must write configuration registers through the cfg
// port only while no item is in flight; the block itself does not enforce this.
`default_nettype none

module capacitance_acquire_sequencer import cas_pkg::*; (
  input  wire         clk,
  input  wire         rst_n,
  input  wire         in_tvalid,
  output logic        in_tready,
  input  wire  [31:0] in_tdata,   // read_data[31:0]
  input  wire  [2:0]  in_tuser,   // func[2:0]
  output logic        out_tvalid,
  input  wire         out_tready,
  // phase[3:0], read_request[4], read_address[12:5], result_value[44:13],
  // result_valid[45], failure_count[53:46], zero fill[55:54]
  output logic [55:0] out_tdata,
  input  wire         cfg_we,
  input  wire  [2:0]  cfg_index,
  input  wire  [15:0] cfg_wdata
);

  // configuration
  logic [15:0] timeout_r;
  logic [7:0]  thresh_r;
  logic [4:0]  rdy_bit_r;
  logic [7:0]  stat_addr_r;
  logic [7:0]  samp_addr_r;

  // sequencer state
  logic [3:0]        phase_r, phase_nxt;
  logic [7:0]        fail_r, fail_nxt;
  logic [15:0]       wait_r, wait_nxt;
  logic              pend_r, pend_nxt;
  logic [SIDX_W-1:0] sidx_r, sidx_nxt;
  logic [SAMPLE_COUNT-2:0][SAMPLE_W-1:0] store_r;

  // result register
  logic        out_valid_r;
  logic [3:0]  res_phase_r;
  logic        res_req_r, res_req_nxt;
  logic [7:0]  res_addr_r, res_addr_nxt;
  logic [31:0] res_value_r, res_value_nxt;
  logic        res_valid_r, res_valid_nxt;
  logic [7:0]  res_fail_r;

  logic              in_acc;
  logic [2:0]        func;
  logic [31:0]       data;
  logic [15:0]       limit;
  logic [15:0]       wait_inc;
  logic [7:0]        fail_sat;
  logic              ready_hit;
  logic [SIDX_W-1:0] sidx_inc;
  logic              store_we;
  sample_vec_t       med_in;
  logic [31:0]       median;

  assign in_tready = !out_valid_r || out_tready;
  assign in_acc    = in_tvalid && in_tready;
  assign func      = in_tuser;
  assign data      = in_tdata;
  assign limit     = (timeout_r == 16'd0) ? 16'd1 : timeout_r;
  assign wait_inc  = wait_r + 16'd1;
  assign fail_sat  = (fail_r == 8'hFF) ? fail_r : fail_r + 8'd1;
  assign ready_hit = data[rdy_bit_r];
  assign sidx_inc  = sidx_r + SIDX_W'(1);

  // the fifth sample joins the network straight from the input
  always_comb begin
    for (int i = 0; i < SAMPLE_COUNT - 1; i++) begin
      med_in[i] = store_r[i];
    end
    med_in[SAMPLE_COUNT-1] = data;
  end

  cas_median5 u_median (
    .samples (med_in),
    .median  (median)
  );

  always_comb begin
    phase_nxt     = phase_r;
    fail_nxt      = fail_r;
    wait_nxt      = wait_r;
    pend_nxt      = pend_r;
    sidx_nxt      = sidx_r;
    res_req_nxt   = 1'b0;
    res_addr_nxt  = 8'd0;
    res_value_nxt = 32'd0;
    res_valid_nxt = 1'b0;
    store_we      = 1'b0;
    case (func)
      FN_INIT: begin
        fail_nxt  = 8'd0;
        wait_nxt  = 16'd0;
        pend_nxt  = 1'b0;
        sidx_nxt  = '0;
        phase_nxt = PH_INITDONE;
      end
      FN_START: begin
        wait_nxt  = 16'd0;
        pend_nxt  = 1'b0;
        sidx_nxt  = '0;
        phase_nxt = PH_WAITINT;
      end
      FN_TICK: begin
        if (phase_r == PH_WAITINT) begin
          wait_nxt = wait_inc;
          if (wait_inc >= limit) begin
            phase_nxt    = PH_WAITREADY;
            wait_nxt     = 16'd0;
            pend_nxt     = 1'b1;
            res_req_nxt  = 1'b1;
            res_addr_nxt = stat_addr_r;
          end
        end else if (phase_r == PH_WAITREADY && !pend_r) begin
          pend_nxt     = 1'b1;
          res_req_nxt  = 1'b1;
          res_addr_nxt = stat_addr_r;
        end
      end
      FN_INTR: begin
        if (phase_r == PH_WAITINT) begin
          phase_nxt    = PH_CONFIRM;
          wait_nxt     = 16'd0;
          pend_nxt     = 1'b1;
          res_req_nxt  = 1'b1;
          res_addr_nxt = stat_addr_r;
        end
      end
      FN_DATA: begin
        if (pend_r) begin
          if (phase_r == PH_WAITREADY) begin
            if (ready_hit) begin
              phase_nxt    = PH_CONFIRM;
              wait_nxt     = 16'd0;
              pend_nxt     = 1'b1;
              res_req_nxt  = 1'b1;
              res_addr_nxt = stat_addr_r;
            end else begin
              wait_nxt = wait_inc;
              pend_nxt = 1'b0;
              if (wait_inc >= limit) begin
                fail_nxt  = fail_sat;
                phase_nxt = (fail_sat >= thresh_r) ? PH_FAULT : PH_TIMEOUT;
                wait_nxt  = 16'd0;
              end
            end
          end else if (phase_r == PH_CONFIRM) begin
            if (ready_hit) begin
              phase_nxt    = PH_SAMPLING;
              sidx_nxt     = '0;
              pend_nxt     = 1'b1;
              res_req_nxt  = 1'b1;
              res_addr_nxt = samp_addr_r;
            end else begin
              fail_nxt  = fail_sat;
              phase_nxt = (fail_sat >= thresh_r) ? PH_FAULT : PH_NOTREADY;
              pend_nxt  = 1'b0;
              wait_nxt  = 16'd0;
            end
          end else if (phase_r == PH_SAMPLING) begin
            if (sidx_inc >= SIDX_W'(SAMPLE_COUNT)) begin
              res_value_nxt = median;
              res_valid_nxt = 1'b1;
              fail_nxt      = 8'd0;
              pend_nxt      = 1'b0;
              sidx_nxt      = '0;
              phase_nxt     = PH_VALID;
            end else begin
              store_we     = 1'b1;
              sidx_nxt     = sidx_inc;
              res_req_nxt  = 1'b1;
              res_addr_nxt = samp_addr_r;
            end
          end
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      timeout_r   <= RST_TIMEOUT;
      thresh_r    <= RST_THRESHOLD;
      rdy_bit_r   <= RST_READY_BIT;
      stat_addr_r <= RST_STAT_ADDR;
      samp_addr_r <= RST_SAMP_ADDR;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_TIMEOUT:   timeout_r   <= cfg_wdata;
        CFG_THRESHOLD: thresh_r    <= cfg_wdata[7:0];
        CFG_READY_BIT: rdy_bit_r   <= cfg_wdata[4:0];
        CFG_STAT_ADDR: stat_addr_r <= cfg_wdata[7:0];
        CFG_SAMP_ADDR: samp_addr_r <= cfg_wdata[7:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_NOTINIT;
      fail_r      <= 8'd0;
      wait_r      <= 16'd0;
      pend_r      <= 1'b0;
      sidx_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_acc) begin
        phase_r <= phase_nxt;
        fail_r  <= fail_nxt;
        wait_r  <= wait_nxt;
        pend_r  <= pend_nxt;
        sidx_r  <= sidx_nxt;
      end
      if (in_acc) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      res_phase_r <= phase_nxt;
      res_req_r   <= res_req_nxt;
      res_addr_r  <= res_addr_nxt;
      res_value_r <= res_value_nxt;
      res_valid_r <= res_valid_nxt;
      res_fail_r  <= fail_nxt;
      if (store_we) begin
        store_r[sidx_r[1:0]] <= data;
      end
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {2'b00, res_fail_r, res_valid_r, res_value_r, res_addr_r,
                       res_req_r, res_phase_r};

  a_valid_phase: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && res_valid_r) |-> (res_phase_r == PH_VALID && !res_req_r && res_fail_r == 8'd0))
    else $error("completed measurement reported with wrong phase, request or count");

  a_addr_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !res_req_r) |-> (res_addr_r == 8'd0))
    else $error("read address set without a read request");

  a_value_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !res_valid_r) |-> (res_value_r == 32'd0))
    else $error("result value set without a completed measurement");

  a_accept_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> (out_valid_r && res_phase_r == phase_r && res_fail_r == fail_r))
    else $error("result item does not match the updated state");

  a_sidx_range: assert property (@(posedge clk) disable iff (!rst_n)
    sidx_r < SIDX_W'(SAMPLE_COUNT))
    else $error("sample index out of range");

endmodule

`default_nettype wire
